>>> rtl/core/srow_pkg.sv
`timescale 1ns / 1ps
package srow_pkg;

  localparam int unsigned LogitW = 16;
  localparam int unsigned ExpW   = 16;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned IdxW   = 4;
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  // Queue entry from the loader to the row engine.
  typedef struct packed {
    logic [LogitW-1:0] neg;
    logic              last;
    logic              ovf;
  } item_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/srow_ram.sv
`timescale 1ns / 1ps
module srow_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/srow_front.sv
`timescale 1ns / 1ps
// Loads a row into the logit store, tracks the maximum, then streams
// (max - logit) for each stored class into the queue.
module srow_front #(
  parameter int unsigned MaxClasses = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         in_logit_i,
  input  logic                in_last_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output srow_pkg::item_t     q_item_o
);
  localparam int unsigned AW = $clog2(MaxClasses);
  localparam int unsigned CW = $clog2(MaxClasses + 1);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      rd_q, rd_d;
  logic signed [15:0] max_q, max_d;
  logic               ovf_q, ovf_d;
  logic               we;
  logic [15:0]        rdata;
  logic               acc;

  srow_ram #(.Width(16), .Depth(MaxClasses)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(in_logit_i),
    .raddr_i(rd_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign in_ready_o = (state_q == S_LOAD);
  assign acc        = in_valid_i && in_ready_o;
  assign we         = acc && (cnt_q < CW'(MaxClasses));
  assign q_valid_o  = (state_q == S_EMIT);
  assign q_item_o.neg  = 16'(max_q - $signed(rdata));
  assign q_item_o.last = (rd_q + CW'(1) == cnt_q);
  assign q_item_o.ovf  = ovf_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rd_d    = rd_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      S_LOAD: begin
        if (acc) begin
          if (we) begin
            cnt_d = cnt_q + CW'(1);
            if ($signed(in_logit_i) > max_q) max_d = $signed(in_logit_i);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            rd_d    = '0;
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (q_ready_i) begin
          if (q_item_o.last) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            max_d   = -16'sd32768;
            ovf_d   = 1'b0;
          end else begin
            rd_d    = rd_q + CW'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      rd_q    <= '0;
      max_q   <= -16'sd32768;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
    end
  end
endmodule

>>> rtl/core/srow_fifo.sv
`timescale 1ns / 1ps
module srow_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srow_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srow_pkg::item_t out_item_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  srow_pkg::item_t mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   n_q;
  logic            push, pop;

  assign in_ready_o  = (n_q != CW'(Depth));
  assign out_valid_o = (n_q != '0);
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q  <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      n_q <= n_q + CW'(push) - CW'(pop);
    end
  end
endmodule

>>> rtl/core/srow_back.sv
`timescale 1ns / 1ps
// Exponential per item into the exp store with running sum, then a
// restoring divider per class and an output register.
module srow_back #(
  parameter int unsigned MaxClasses = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  srow_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     out_prob_o,
  output logic [3:0]      out_idx_o,
  output logic            out_last_o,
  output logic            out_ovf_o
);
  localparam int unsigned AW = $clog2(MaxClasses);
  localparam int unsigned CW = $clog2(MaxClasses + 1);
  localparam int unsigned SW = $clog2(MaxClasses * 65535 + 1);
  localparam int unsigned NW = SW + 2;

  typedef enum logic [5:0] {
    S_EXP  = 6'b000001,
    S_EXP2 = 6'b000010,
    S_RD   = 6'b000100,
    S_LD   = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [32:0]    t_q, t_d;
  logic [CW-1:0]  cnt_q, cnt_d, idx_q, idx_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic           ovf_q, ovf_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [32:0]    num_q, num_d;
  logic [5:0]     step_q, step_d;
  logic [16:0]    quo_q, quo_d;
  logic           ov_q, ov_d, ol_q, ol_d;
  logic [15:0]    op_q, op_d;
  logic [3:0]     oi_q, oi_d;
  logic           oo_q, oo_d;
  logic           lastin_q, lastin_d;

  logic [7:0]     f;
  logic [24:0]    ip;
  logic [16:0]    ta, tb, v;
  logic [21:0]    dr;
  logic [16:0]    e;
  logic [15:0]    esat;
  logic           we;
  logic [15:0]    rdata;
  logic [NW-1:0]  trial;
  logic           obusy;

  srow_ram #(.Width(16), .Depth(MaxClasses)) u_exp (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(esat),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign ip   = t_q[32:8];
  assign f    = t_q[7:0];
  assign ta   = srow_pkg::pow2_tab({1'b0, f[7:4]});
  assign tb   = srow_pkg::pow2_tab({1'b0, f[7:4]} + 5'd1);
  assign dr   = 22'(ta - tb) * 22'(f[3:0]);
  assign v    = ta - 17'(dr >> 4);
  assign e    = (ip >= 25'd17) ? 17'd0 : (v >> ip[4:0]);
  assign esat = e[16] ? 16'hFFFF : e[15:0];
  assign we   = (state_q == S_EXP2);

  assign q_ready_o   = (state_q == S_EXP);
  assign obusy       = ov_q && !out_ready_i;
  assign out_valid_o = ov_q;
  assign out_prob_o  = op_q;
  assign out_idx_o   = oi_q;
  assign out_last_o  = ol_q;
  assign out_ovf_o   = oo_q;

  assign trial = {rem_q[NW-2:0], num_q[32]};

  always_comb begin
    state_d = state_q; t_d = t_q; cnt_d = cnt_q; idx_d = idx_q;
    sum_d = sum_q; ovf_d = ovf_q; rem_d = rem_q; num_d = num_q;
    step_d = step_q; quo_d = quo_q; lastin_d = lastin_q;
    ov_d = ov_q && !out_ready_i; op_d = op_q; oi_d = oi_q; ol_d = ol_q; oo_d = oo_q;
    unique case (state_q)
      S_EXP: begin
        if (q_valid_i) begin
          t_d      = 33'((34'(q_item_i.neg) * 34'(srow_pkg::Log2eQ16)) >> 16);
          ovf_d    = q_item_i.ovf;
          lastin_d = q_item_i.last;
          state_d  = S_EXP2;
        end
      end
      S_EXP2: begin
        sum_d = sum_q + SW'(esat);
        cnt_d = cnt_q + CW'(1);
        if (lastin_q) begin
          idx_d   = '0;
          state_d = S_RD;
        end else begin
          state_d = S_EXP;
        end
      end
      S_RD: state_d = S_LD;
      S_LD: begin
        num_d   = {1'b0, rdata, 16'd0} + 33'(sum_q >> 1);
        rem_d   = '0;
        quo_d   = '0;
        step_d  = 6'd33;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (trial >= NW'(sum_q)) begin
          rem_d = trial - NW'(sum_q);
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[15:0], 1'b0};
        end
        if (step_q > 6'd17 && quo_q != '0) quo_d = 17'h1FFFF;
        num_d  = {num_q[31:0], 1'b0};
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) state_d = S_OUT;
      end
      S_OUT: begin
        if (!obusy) begin
          ov_d = 1'b1;
          op_d = (quo_q[16] || (sum_q == '0)) ?
                 ((sum_q == '0) ? 16'd0 : 16'hFFFF) : quo_q[15:0];
          oi_d = idx_q[3:0];
          ol_d = (idx_q + CW'(1) == cnt_q);
          oo_d = ovf_q;
          if (idx_q + CW'(1) == cnt_q) begin
            cnt_d = '0; sum_d = '0; state_d = S_EXP;
          end else begin
            idx_d = idx_q + CW'(1); state_d = S_RD;
          end
        end
      end
      default: state_d = S_EXP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EXP; cnt_q <= '0; idx_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
      ov_q <= 1'b0; step_q <= '0; lastin_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d; sum_q <= sum_d;
      ovf_q <= ovf_d; ov_q <= ov_d; step_q <= step_d; lastin_q <= lastin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; rem_q <= rem_d; num_q <= num_d; quo_q <= quo_d;
    op_q <= op_d; oi_q <= oi_d; ol_q <= ol_d; oo_q <= oo_d;
  end
endmodule

>>> rtl/core/softmax_row_unit_top.sv
`timescale 1ns / 1ps
// Softmax over one row of Q8.8 logits (tlast on the final logit). Logits load one
// per cycle, while the loader is in its load state, into a store of MAX_CLASSES
// entries; extra logits are dropped and the row's results carry the overflow flag.
// After the last logit each class has its exponential formed, then passes through
// the bit-serial divider (33 steps) before its probability leaves; the next row
// may load while the previous one is divided.
module softmax_row_unit_top #(
  parameter int unsigned MAX_CLASSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] logit
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [15:0] probability, [19:16] class_index
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o   // row_overflow
);
  logic            fq_valid, fq_ready, bq_valid, bq_ready;
  srow_pkg::item_t fq_item, bq_item;
  logic [15:0]     prob;
  logic [3:0]      idx;

  srow_front #(.MaxClasses(MAX_CLASSES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_logit_i(s_axis_tdata_i), .in_last_i(s_axis_tlast_i),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_item_o(fq_item)
  );

  srow_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(fq_valid), .in_ready_o(fq_ready), .in_item_i(fq_item),
    .out_valid_o(bq_valid), .out_ready_i(bq_ready), .out_item_o(bq_item)
  );

  srow_back #(.MaxClasses(MAX_CLASSES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(bq_valid), .q_ready_o(bq_ready), .q_item_i(bq_item),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_prob_o(prob), .out_idx_o(idx),
    .out_last_o(m_axis_tlast_o), .out_ovf_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'd0, idx, prob};
endmodule

>>> tb/tb_softmax_row_unit_top.sv
`timescale 1ns / 1ps
module tb_softmax_row_unit_top;

  localparam int unsigned MaxCls = 16;
  localparam int unsigned NumRand = 165;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct {
    logic [srow_pkg::ProbW-1:0] prob;
    logic [srow_pkg::IdxW-1:0]  idx;
    logic                       last;
    logic                       ovf;
  } prob_t;

  typedef struct {
    logic [srow_pkg::LogitW-1:0] logit;
    logic                        last;
    logic                        has_exp;
    logic [srow_pkg::ProbW-1:0]  exp_prob0;
  } stim_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  softmax_row_unit_top #(.MAX_CLASSES(MaxCls)) u_top (.*);

  // predictor state
  logic signed [srow_pkg::LogitW-1:0] row_logits[MaxCls];
  int unsigned                        row_len;
  logic signed [srow_pkg::LogitW-1:0] row_max;
  logic                               row_dropped;

  prob_t       prob_q[$];
  int unsigned n_err;
  longint unsigned cyc;
  bit          sink_hold;
  bit          sink_calm;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %0d want %0d at cycle %0d", what, got, want, cyc);
    n_err++;
  endtask

  function automatic logic [16:0] exp_q16(input logic [15:0] neg);
    logic [33:0] t;
    logic [17:0] ip;
    logic [7:0]  f;
    logic [16:0] tk, tk1, v, e;
    int unsigned k;
    logic [31:0] tab[17];
    tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
            44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    t  = (34'(neg) * 34'd94548) >> 16;
    ip = t[25:8];
    f  = t[7:0];
    if (ip >= 17) return 0;
    k   = f[7:4];
    tk  = 17'(tab[k]);
    tk1 = 17'(tab[k+1]);
    v   = tk - 17'((32'(tk - tk1) * f[3:0]) >> 4);
    e   = v >> ip;
    return (e > 65535) ? 17'd65535 : e;
  endfunction

  task automatic load_logit(input logic [15:0] raw, input logic last);
    logic [16:0] ex[MaxCls];
    logic [63:0] sum, p;
    prob_t       r;
    if (row_len < MaxCls) begin
      row_logits[row_len] = raw;
      row_len++;
      if ($signed(raw) > row_max) row_max = raw;
    end else begin
      row_dropped = 1'b1;
    end
    if (!last) return;
    sum = 0;
    for (int i = 0; i < row_len; i++) begin
      ex[i] = exp_q16(16'(row_max - row_logits[i]));
      sum += ex[i];
    end
    for (int i = 0; i < row_len; i++) begin
      p = (sum == 0) ? 0 : (((64'(ex[i])) << 16) + (sum >> 1)) / sum;
      r.prob = (p > 65535) ? 16'hFFFF : p[15:0];
      r.idx  = i[3:0];
      r.last = (i + 1 == row_len);
      r.ovf  = row_dropped;
      prob_q = {prob_q, r};
    end
    row_len = 0;
    row_max = -16'sd32768;
    row_dropped = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("softmax_row_unit_top test failed");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    prob_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (prob_q.size() == 0) begin
        report("unexpected transaction", m_axis_tdata_o[15:0], 0);
      end else begin
        want = prob_q.pop_front();
        if (m_axis_tdata_o[15:0] !== want.prob)
          report("probability", m_axis_tdata_o[15:0], want.prob);
        if (m_axis_tdata_o[19:16] !== want.idx)
          report("class_index", m_axis_tdata_o[19:16], want.idx);
        if (m_axis_tdata_o[23:20] !== 4'd0)
          report("tdata pad", m_axis_tdata_o[23:20], 0);
        if (m_axis_tlast_o !== want.last) report("tlast", m_axis_tlast_o, want.last);
        if (m_axis_tuser_o !== want.ovf) report("row_overflow", m_axis_tuser_o, want.ovf);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, calm at the end
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (3000) @(negedge clk_i);
        sink_hold = 1'b0;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // valid stays high after a transaction until the next call or an explicit idle
  task automatic send(input logic [15:0] raw, input logic last, input bit calm);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    load_logit(raw, last);
    @(negedge clk_i);
  endtask

  stim_t directed[] = '{
    '{16'h7FFF, 1'b1, 1'b1, 16'hFFFF},  // single class saturates
    '{16'h8000, 1'b1, 1'b1, 16'hFFFF},
    '{16'h0000, 1'b0, 1'b0, 16'h0},     // two equal classes
    '{16'h0000, 1'b1, 1'b1, 16'h8000},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0},     // max spread
    '{16'h8000, 1'b1, 1'b1, 16'hFFFF},
    '{16'h5555, 1'b0, 1'b0, 16'h0},
    '{16'hAAAA, 1'b0, 1'b0, 16'h0},
    '{16'h0100, 1'b0, 1'b0, 16'h0},
    '{16'hFF00, 1'b1, 1'b0, 16'h0}
  };

  initial begin
    int unsigned len;
    bit calm;
    n_err = 0; cyc = 0; sink_hold = 0; sink_calm = 0;
    row_len = 0; row_max = -16'sd32768; row_dropped = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      // drain so the row's first result heads the queue
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while (prob_q.size() != 0);
      send(directed[i].logit, directed[i].last, 0);
      if (directed[i].has_exp && prob_q.size() > 0 && prob_q[0].prob !== directed[i].exp_prob0)
        report("directed first probability", prob_q[0].prob, directed[i].exp_prob0);
    end
    // overlong row: 20 logits, last four dropped
    for (int i = 0; i < 20; i++) send(16'($urandom), i == 19, 0);
    // hold-off with a full row behind it
    sink_hold = 1'b1;
    for (int i = 0; i < 16; i++) send(16'($urandom_range(0, 2047)), i == 15, 0);

    for (int n = 0; n < NumRand; n += len) begin
      calm = (n > NumRand - 40);
      sink_calm = calm;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: send(16'($urandom), i == len - 1, calm);
          1: send(16'($urandom_range(0, 2047)) - 16'd1024, i == len - 1, calm);
          2: send(16'($urandom_range(0, 255)), i == len - 1, calm);
          default: send(($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000, i == len - 1, calm);
        endcase
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (prob_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_err == 0) begin
      $display("softmax_row_unit_top test passed");
    end else begin
      $display("softmax_row_unit_top test failed");
    end
    $finish;
  end

endmodule

>>> softmax_row_unit_top.f
rtl/core/srow_pkg.sv
rtl/core/srow_ram.sv
rtl/core/srow_front.sv
rtl/core/srow_fifo.sv
rtl/core/srow_back.sv
rtl/core/softmax_row_unit_top.sv
tb/tb_softmax_row_unit_top.sv
